[hw/rtl/box_average_downscale_macros.svh]
// Assertion macros for the box average downscaler checker.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef BOX_AVERAGE_DOWNSCALE_MACROS_SVH
`define BOX_AVERAGE_DOWNSCALE_MACROS_SVH

// Consequent in the same cycle
`define BAVG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the following cycle
`define BAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bavg_pkg.sv]
// Shared types and constants for the box average downscaler.
// No dependencies.
package bavg_pkg;

   localparam int PIX_W        = 8;
   localparam int SUM_W        = 16;
   localparam int CFG_SIZE_W   = 11;
   localparam int CFG_FACTOR_W = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_FACTOR = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR_H   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR_V   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_DIV
   } bavg_state_type;

endpackage

[hw/rtl/box_average_downscale.sv]
// Box average downscaler: RGB pixels in raster order are summed per block of
// factor_h x factor_v pixels and one mean pixel is given per complete block.
// One pixel is taken at a time. Every pixel passes accept with the sum memory
// read, the block bound products, and add and write back on the single port sum
// memory; one that completes a block also passes the 16-step bit-serial divider
// and the result load. A finished result waits in the output register while the
// next pixel is taken. The user must write configuration only while idle; the
// block does not enforce it. The sum memory needs no clearing pass.
// Depends on bavg_pkg and bavg_div.
module box_average_downscale #(
   parameter int MAX_WIDTH  = bavg_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bavg_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bavg_pkg::PIX_W-1:0]          req_in_red,
   input  logic [bavg_pkg::PIX_W-1:0]          req_in_green,
   input  logic [bavg_pkg::PIX_W-1:0]          req_in_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bavg_pkg::PIX_W-1:0]          rsp_out_red,
   output logic [bavg_pkg::PIX_W-1:0]          rsp_out_green,
   output logic [bavg_pkg::PIX_W-1:0]          rsp_out_blue,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bavg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bavg_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bavg_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int IW    = $clog2(MAX_FACTOR);
   localparam int FW    = $clog2(MAX_FACTOR + 1);
   localparam int CNT_W = 2 * FW;
   localparam int SWC   = (WW > CFG_SIZE_W) ? WW : CFG_SIZE_W;
   localparam int SHC   = (HW > CFG_SIZE_W) ? HW : CFG_SIZE_W;
   localparam int SFC   = (FW > CFG_FACTOR_W) ? FW : CFG_FACTOR_W;
   localparam int PCW   = CW + 1 + FW;
   localparam int PRW   = RW + 1 + FW;
   localparam int MW    = 3 * SUM_W;

   bavg_state_type state_ff, state_in;

   logic [CFG_SIZE_W-1:0]   src_width_ff, src_height_ff;
   logic [CFG_FACTOR_W-1:0] factor_h_ff, factor_v_ff;

   logic [CW-1:0] col_count_ff, block_col_ff;
   logic [RW-1:0] row_count_ff, block_row_ff;
   logic [IW-1:0] col_in_block_ff, row_in_block_ff;

   logic [PIX_W-1:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic [MW-1:0]    sum_mem [MAX_WIDTH];
   logic [MW-1:0]    rd_ff;
   logic [PCW-1:0]   prod_c_ff;
   logic [PRW-1:0]   prod_r_ff;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] out_r_ff, out_g_ff, out_b_ff;
   logic             row_end_ff, frame_end_ff, re_ff, fe_ff;

   logic [WW-1:0] w;
   logic [HW-1:0] h;
   logic [FW-1:0] fh, fv;
   logic [SWC-1:0] sw_ext;
   logic [SHC-1:0] sh_ext;
   logic [SFC-1:0] fh_ext, fv_ext;

   logic row_last, frame_last, cib_last, rib_last, first;
   logic col_ok, row_ok, re, fe, emit;
   logic [PCW-1:0] prod_c2;
   logic [PRW-1:0] prod_r2;
   logic [2:0][SUM_W-1:0] sums;
   logic [CNT_W-1:0] count;
   logic div_start, div_busy;
   logic [2:0][PIX_W-1:0] means;
   logic req_take, rsp_free;

   assign sw_ext = SWC'(src_width_ff);
   assign sh_ext = SHC'(src_height_ff);
   assign fh_ext = SFC'(factor_h_ff);
   assign fv_ext = SFC'(factor_v_ff);

   assign w  = (sw_ext == '0) ? WW'(1) : (sw_ext > SWC'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(sw_ext);
   assign h  = (sh_ext == '0) ? HW'(1) : (sh_ext > SHC'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(sh_ext);
   assign fh = (fh_ext == '0) ? FW'(1) : (fh_ext > SFC'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(fh_ext);
   assign fv = (fv_ext == '0) ? FW'(1) : (fv_ext > SFC'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(fv_ext);

   assign row_last   = (WW'(col_count_ff) + WW'(1)) >= w;
   assign frame_last = (HW'(row_count_ff) + HW'(1)) >= h;
   assign cib_last   = (FW'(col_in_block_ff) + FW'(1)) >= fh;
   assign rib_last   = (FW'(row_in_block_ff) + FW'(1)) >= fv;
   assign first      = (col_in_block_ff == '0) && (row_in_block_ff == '0);

   assign prod_c2 = prod_c_ff + PCW'(fh);
   assign prod_r2 = prod_r_ff + PRW'(fv);
   assign col_ok  = (block_col_ff == '0) || (prod_c_ff <= PCW'(w));
   assign row_ok  = (block_row_ff == '0) || (prod_r_ff <= PRW'(h));
   assign re      = prod_c2 > PCW'(w);
   assign fe      = re && (prod_r2 > PRW'(h));
   assign emit    = (row_last || cib_last) && (frame_last || rib_last) && col_ok && row_ok;

   always_comb begin
      logic [2:0][PIX_W-1:0] pix;
      pix = {pix_b_ff, pix_g_ff, pix_r_ff};
      for (int c = 0; c < 3; c++) begin
         sums[c] = first ? SUM_W'(pix[c]) : rd_ff[c*SUM_W +: SUM_W] + SUM_W'(pix[c]);
      end
   end

   assign count    = CNT_W'(FW'(col_in_block_ff) + FW'(1)) *
                     CNT_W'(FW'(row_in_block_ff) + FW'(1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            div_start = emit;
            state_in  = emit ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (!div_busy && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CFG_SIZE_W'(1024);
         src_height_ff <= CFG_SIZE_W'(1024);
         factor_h_ff   <= CFG_FACTOR_W'(1);
         factor_v_ff   <= CFG_FACTOR_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_FACTOR_H:   factor_h_ff   <= csr_data[CFG_FACTOR_W-1:0];
            CSR_FACTOR_V:   factor_v_ff   <= csr_data[CFG_FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // sum memory: read on accept, write back after the add
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_ff    <= sum_mem[block_col_ff];
         pix_r_ff <= req_in_red;
         pix_g_ff <= req_in_green;
         pix_b_ff <= req_in_blue;
      end
      if (state_ff == ST_ACC) begin
         sum_mem[block_col_ff] <= {sums[2], sums[1], sums[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         prod_c_ff <= PCW'((CW + 1)'(block_col_ff) + (CW + 1)'(1)) * PCW'(fh);
         prod_r_ff <= PRW'((RW + 1)'(block_row_ff) + (RW + 1)'(1)) * PRW'(fv);
      end
      if (div_start) begin
         re_ff <= re;
         fe_ff <= fe;
      end
   end

   // advance raster position
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         col_in_block_ff <= '0;
         row_in_block_ff <= '0;
         block_col_ff    <= '0;
         block_row_ff    <= '0;
      end else if (state_ff == ST_ACC) begin
         if (row_last) begin
            col_count_ff    <= '0;
            col_in_block_ff <= '0;
            block_col_ff    <= '0;
            if (frame_last) begin
               row_count_ff    <= '0;
               row_in_block_ff <= '0;
               block_row_ff    <= '0;
            end else begin
               row_count_ff <= row_count_ff + RW'(1);
               if (rib_last) begin
                  row_in_block_ff <= '0;
                  block_row_ff    <= block_row_ff + RW'(1);
               end else begin
                  row_in_block_ff <= row_in_block_ff + IW'(1);
               end
            end
         end else begin
            col_count_ff <= col_count_ff + CW'(1);
            if (cib_last) begin
               col_in_block_ff <= '0;
               block_col_ff    <= block_col_ff + CW'(1);
            end else begin
               col_in_block_ff <= col_in_block_ff + IW'(1);
            end
         end
      end
   end

   bavg_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .count (count),
      .sums  (sums),
      .busy  (div_busy),
      .means (means)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DIV && !div_busy && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && !div_busy && rsp_free) begin
         out_r_ff     <= means[0];
         out_g_ff     <= means[1];
         out_b_ff     <= means[2];
         row_end_ff   <= re_ff;
         frame_end_ff <= fe_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

[hw/rtl/bavg_div.sv]
// Bit-serial restoring divider: three block sums by one pixel count, saturated to 8 bits.
// Depends on bavg_pkg.
module bavg_div #(
   parameter int CNT_W = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [CNT_W-1:0]                         count,
   input  logic [2:0][bavg_pkg::SUM_W-1:0]          sums,
   output logic                                     busy,
   output logic [2:0][bavg_pkg::PIX_W-1:0]          means
);
   import bavg_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic                    busy_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [2:0][SUM_W-1:0]   dvd_ff, dvd_in;
   logic [2:0][CNT_W-1:0]   rem_ff, rem_in;

   always_comb begin
      logic [CNT_W:0] rem_sh;
      logic           ge;
      for (int c = 0; c < 3; c++) begin
         rem_sh    = {rem_ff[c], dvd_ff[c][SUM_W-1]};
         ge        = rem_sh >= {1'b0, cnt_ff};
         rem_in[c] = ge ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : CNT_W'(rem_sh);
         dvd_in[c] = {dvd_ff[c][SUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= count;
         dvd_ff <= sums;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         means[c] = (|dvd_ff[c][SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : dvd_ff[c][PIX_W-1:0];
      end
   end

   assign busy = busy_ff;

endmodule

[hw/rtl/bavg_checker.sv]
// Port-level checks for the box average downscaler, bound to the top level.
// Depends on box_average_downscale_macros.svh.
`include "box_average_downscale_macros.svh"

module bavg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic       rsp_row_end,
   input logic       rsp_frame_end
);

   `BAVG_ASSERT_NOW(a_frame_row, rsp_valid && rsp_frame_end, rsp_row_end, "frame end without row end")
   `BAVG_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "item taken while busy")
   `BAVG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled item dropped")
   `BAVG_ASSERT_NEXT(a_rsp_data, rsp_valid && rsp_stall, $stable(rsp_out_red), "stalled item changed")

endmodule

bind box_average_downscale bavg_checker u_bavg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);
